### hw/rtl/kbdev_pkg.sv
// Shared constants and types for the keyboard report event generator.
// Used by kbdev_ctrl, kbdev_dp and keyboard_report_to_key_events.
package kbdev_pkg;

   localparam int KEY_SLOTS     = 6;
   localparam int MODIFIER_BITS = 8;
   localparam int INPUT_SLOTS   = 6;
   localparam int CODE_W        = 8;
   localparam int MOD_FIELD_W   = 8;

   localparam int REQ_DATA_W = MOD_FIELD_W + CODE_W * INPUT_SLOTS;
   localparam int EV_N       = MODIFIER_BITS + 2 * KEY_SLOTS;

   localparam logic [CODE_W-1:0] CODE_MIN      = CODE_W'(2);
   localparam logic [CODE_W-1:0] CODE_MAX      = CODE_W'(8'h9f);
   localparam logic [CODE_W-1:0] MOD_BASE_INIT = CODE_W'(224);

   localparam logic EV_KEY_UP   = 1'b0;
   localparam logic EV_KEY_DOWN = 1'b1;

   typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] code_array_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic calc;
      logic pop;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ev_any;
      logic out_free;
   } dp_status_type;

endpackage

### hw/rtl/kbdev_ctrl.sv
// Sequencer for the keyboard report event generator.
// Depends on kbdev_pkg; drives the command struct of kbdev_dp.
module kbdev_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  kbdev_pkg::dp_status_type status,
   output kbdev_pkg::ctrl_cmd_type  cmd
);
   import kbdev_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.ev_any) begin
               cmd.pop = status.out_free;
            end else begin
               // all events handed off: make this report the stored one
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> state_ff == ST_IDLE)
      else $error("capture outside idle");

   a_calc_then_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.calc |=> state_ff == ST_EMIT)
      else $error("calc not followed by emit");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_tready)
      else $error("commit not followed by idle");

endmodule

### hw/rtl/kbdev_dp.sv
// Datapath of the keyboard report event generator: stored report, event
// vector, event select and output register. Depends on kbdev_pkg.
module kbdev_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  kbdev_pkg::ctrl_cmd_type             cmd,
   output kbdev_pkg::dp_status_type            status,
   input  logic [kbdev_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                csr_we,
   input  logic [kbdev_pkg::CODE_W-1:0]        csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kbdev_pkg::CODE_W-1:0]        rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import kbdev_pkg::*;

   function automatic logic [CODE_W-1:0] filter_code(input logic [CODE_W-1:0] c);
      if (c < CODE_MIN || c > CODE_MAX) begin
         return '0;
      end
      return c;
   endfunction

   logic [CODE_W-1:0]        base_ff, base_in;
   logic [MODIFIER_BITS-1:0] prev_mods_ff, prev_mods_in;
   logic [MODIFIER_BITS-1:0] new_mods_ff, new_mods_in;
   code_array_type           prev_keys_ff, prev_keys_in;
   code_array_type           new_keys_ff, new_keys_in;
   logic [EV_N-1:0]          ev_ff, ev_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [CODE_W-1:0]        rsp_code_ff, rsp_code_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [EV_N-1:0]          ev_calc;
   logic [EV_N-1:0]          sel;
   logic [KEY_SLOTS-1:0]     new_seen;
   logic [KEY_SLOTS-1:0]     old_seen;
   logic                     sel_kind;
   logic [CODE_W-1:0]        sel_code;
   code_array_type           req_keys;

   assign status.ev_any   = |ev_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // filter incoming slots; slots past the report read as empty
   always_comb begin
      req_keys = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (i < INPUT_SLOTS) begin
            req_keys[i] = filter_code(req_tdata[MOD_FIELD_W + CODE_W*i +: CODE_W]);
         end
      end
   end

   // one bit per possible event, in emission order
   always_comb begin
      new_seen = '0;
      old_seen = '0;
      ev_calc  = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev_keys_ff[j] == new_keys_ff[i]) new_seen[i] = 1'b1;
            if (new_keys_ff[j] == prev_keys_ff[i]) old_seen[i] = 1'b1;
         end
      end
      for (int i = 0; i < MODIFIER_BITS; i++) begin
         ev_calc[i] = new_mods_ff[i] ^ prev_mods_ff[i];
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         ev_calc[MODIFIER_BITS + i] = (new_keys_ff[i] != '0) && !new_seen[i];
         ev_calc[MODIFIER_BITS + KEY_SLOTS + i] =
            (prev_keys_ff[i] != '0) && !old_seen[i];
      end
   end

   // lowest pending event
   assign sel = ev_ff & (~ev_ff + EV_N'(1));

   always_comb begin
      sel_kind = EV_KEY_UP;
      sel_code = '0;
      for (int k = 0; k < MODIFIER_BITS; k++) begin
         if (sel[k]) begin
            sel_kind = new_mods_ff[k];
            sel_code = base_ff + CODE_W'(k);
         end
      end
      for (int k = 0; k < KEY_SLOTS; k++) begin
         if (sel[MODIFIER_BITS + k]) begin
            sel_kind = EV_KEY_DOWN;
            sel_code = new_keys_ff[k];
         end
         if (sel[MODIFIER_BITS + KEY_SLOTS + k]) begin
            sel_kind = EV_KEY_UP;
            sel_code = prev_keys_ff[k];
         end
      end
   end

   always_comb begin
      base_in      = csr_we ? csr_data : base_ff;
      new_mods_in  = cmd.capture ? req_tdata[MODIFIER_BITS-1:0] : new_mods_ff;
      new_keys_in  = cmd.capture ? req_keys : new_keys_ff;
      prev_mods_in = cmd.commit ? new_mods_ff : prev_mods_ff;
      prev_keys_in = cmd.commit ? new_keys_ff : prev_keys_ff;

      priority if (cmd.calc) begin
         ev_in = ev_calc;
      end else if (cmd.pop) begin
         ev_in = ev_ff & ~sel;
      end else begin
         ev_in = ev_ff;
      end

      rsp_kind_in = rsp_kind_ff;
      rsp_code_in = rsp_code_ff;
      rsp_last_in = rsp_last_ff;
      priority if (cmd.pop) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = sel_kind;
         rsp_code_in  = sel_code;
         rsp_last_in  = (ev_ff & ~sel) == '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= MOD_BASE_INIT;
         prev_mods_ff <= '0;
         prev_keys_ff <= '0;
         ev_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         prev_mods_ff <= prev_mods_in;
         prev_keys_ff <= prev_keys_in;
         ev_ff        <= ev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_mods_ff <= new_mods_in;
      new_keys_ff <= new_keys_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_pop_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> ev_ff != '0)
      else $error("pop with no pending event");

   a_pop_one: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> $countones(ev_ff) == $countones($past(ev_ff)) - 1)
      else $error("pop did not retire exactly one event");

   a_capture_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> ev_ff == '0)
      else $error("new report taken with events pending");

   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> ev_ff == '0 && !cmd.pop)
      else $error("commit with events pending");

endmodule

### hw/rtl/keyboard_report_to_key_events.sv
// Keyboard report to key event converter. One report is taken in idle; the
// calc state builds the event list, then one event per cycle enters the
// output register unless the output stalls; the next report waits for idle.
// Output stalls hold the sequencer. Synchronous active-high reset clears
// stored report and sets base to 224.
module keyboard_report_to_key_events (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // modifier_mask, key_slot_0 .. key_slot_5
   input  logic [kbdev_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // key_code
   output logic [kbdev_pkg::CODE_W-1:0]       rsp_tdata,
   // event_kind
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   // modifier_code_base
   input  logic [kbdev_pkg::CODE_W-1:0]       csr_data
);
   import kbdev_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   kbdev_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kbdev_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_valid & csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
